FILE: hw/rtl/fmtile_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmtile_pkg
// shared types and constants for the float matmul tile engine
// ----------------------------------------------------------------------------
package fmtile_pkg;

    localparam int DIM        = 64;
    localparam int IDX_W      = 6;
    localparam int ADDR_W     = 2 * IDX_W;
    localparam int TILE_ROWS  = 8;
    localparam int TILE_COLS  = 4;
    localparam int NSLOTS     = TILE_ROWS * TILE_COLS;
    localparam int SLOT_W     = 5;
    localparam int FMA_LAT    = 8;
    localparam int DRAIN_CYCLES = FMA_LAT + 2;
    localparam int DRAIN_W    = 4;

    localparam logic [1:0] OP_WR_A = 2'd0;
    localparam logic [1:0] OP_WR_B = 2'd1;
    localparam logic [1:0] OP_TILE = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [5:0]  elem_row;
        logic [5:0]  elem_col;
        logic [31:0] elem_value;
        logic [2:0]  tile_row_block;
        logic [3:0]  tile_col_block;
    } req_item_t;

    typedef struct packed {
        logic [5:0]  out_row;
        logic [5:0]  out_col;
        logic [31:0] out_value;
        logic        last_of_tile;
    } res_item_t;

    typedef struct packed {
        logic              wr_a;
        logic              wr_b;
        logic              load_tile;
        logic              issue;
        logic              first_k;
        logic [SLOT_W-1:0] slot;
        logic [IDX_W-1:0]  k;
        logic              emit_load;
        logic              emit_last;
    } dp_cmd_t;

    typedef struct packed {
        logic res_busy;
    } dp_status_t;

endpackage

FILE: hw/rtl/fmtile_fma.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmtile_fma
// pipelined binary32 fused multiply-add, a*b+c, round to nearest even
// ----------------------------------------------------------------------------
module fmtile_fma (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [fmtile_pkg::SLOT_W-1:0] in_tag,
    input  logic [31:0]                   a,
    input  logic [31:0]                   b,
    input  logic [31:0]                   c,
    output logic                          out_valid,
    output logic [fmtile_pkg::SLOT_W-1:0] out_tag,
    output logic [31:0]                   out_value
);

    localparam logic [31:0] QNAN = 32'h7FC0_0000;
    localparam logic [30:0] INF  = 31'h7F80_0000;

    function automatic logic [6:0] lzc64(input logic [63:0] v);
        logic [6:0] n;
        logic       found;
        n = 7'd64;
        found = 1'b0;
        for (int i = 63; i >= 0; i--) begin
            if (!found && v[i])
            begin
                n = 7'(63 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    // valid / tag / special line through all stages
    logic [fmtile_pkg::FMA_LAT-1:0]    v_reg;
    logic [fmtile_pkg::SLOT_W-1:0]     tag_reg [fmtile_pkg::FMA_LAT];
    logic [fmtile_pkg::FMA_LAT-2:0]    spec_reg;
    logic [31:0]                       spval_reg [fmtile_pkg::FMA_LAT-1];

    // stage 1: decode and multiply
    logic [7:0]  ea, eb, ec;
    logic [22:0] fa, fb, fc;
    logic        a_nan, b_nan, c_nan, a_inf, b_inf, c_inf, a_zero, b_zero, c_zero;
    logic        ps, cs;
    logic        spec_next;
    logic [31:0] spval_next;
    logic [23:0] ma, mb, mc;
    logic signed [11:0] xa, xb, xc;

    always_comb
    begin
        ea = a[30:23]; eb = b[30:23]; ec = c[30:23];
        fa = a[22:0];  fb = b[22:0];  fc = c[22:0];
        a_nan  = (ea == 8'hFF) && (fa != '0);
        b_nan  = (eb == 8'hFF) && (fb != '0);
        c_nan  = (ec == 8'hFF) && (fc != '0);
        a_inf  = (ea == 8'hFF) && (fa == '0);
        b_inf  = (eb == 8'hFF) && (fb == '0);
        c_inf  = (ec == 8'hFF) && (fc == '0);
        a_zero = (ea == 8'h00) && (fa == '0);
        b_zero = (eb == 8'h00) && (fb == '0);
        c_zero = (ec == 8'h00) && (fc == '0);
        ps = a[31] ^ b[31];
        cs = c[31];
        ma = {(ea != 8'h00), fa};
        mb = {(eb != 8'h00), fb};
        mc = {(ec != 8'h00), fc};
        xa = $signed({4'b0, (ea == 8'h00) ? 8'd1 : ea}) - 12'sd150;
        xb = $signed({4'b0, (eb == 8'h00) ? 8'd1 : eb}) - 12'sd150;
        xc = $signed({4'b0, (ec == 8'h00) ? 8'd1 : ec}) - 12'sd150;
        spec_next  = 1'b1;
        spval_next = QNAN;
        if (a_nan || b_nan || c_nan)
            spval_next = QNAN;
        else if (a_inf || b_inf)
        begin
            if (a_zero || b_zero || (c_inf && (cs != ps)))
                spval_next = QNAN;
            else
                spval_next = {ps, INF};
        end
        else if (c_inf)
            spval_next = c;
        else if (a_zero || b_zero)
        begin
            if (c_zero)
                spval_next = (ps == cs) ? c : 32'h0;
            else
                spval_next = c;
        end
        else
            spec_next = 1'b0;
    end

    logic [47:0]        s1_mp_reg;
    logic signed [11:0] s1_xp_reg, s1_xc_reg;
    logic [23:0]        s1_mc_reg;
    logic               s1_ps_reg, s1_cs_reg, s1_cz_reg;

    always_ff @(posedge clk)
    begin
        s1_mp_reg <= ma * mb;
        s1_xp_reg <= xa + xb;
        s1_mc_reg <= mc;
        s1_xc_reg <= xc;
        s1_ps_reg <= ps;
        s1_cs_reg <= cs;
        s1_cz_reg <= c_zero;
    end

    // stage 2: leading zero counts
    logic [47:0]        s2_mp_reg;
    logic signed [11:0] s2_xp_reg, s2_xc_reg;
    logic [23:0]        s2_mc_reg;
    logic               s2_ps_reg, s2_cs_reg, s2_cz_reg;
    logic [6:0]         s2_lzp_reg, s2_lzc_reg;

    always_ff @(posedge clk)
    begin
        s2_mp_reg  <= s1_mp_reg;
        s2_xp_reg  <= s1_xp_reg;
        s2_mc_reg  <= s1_mc_reg;
        s2_xc_reg  <= s1_xc_reg;
        s2_ps_reg  <= s1_ps_reg;
        s2_cs_reg  <= s1_cs_reg;
        s2_cz_reg  <= s1_cz_reg;
        s2_lzp_reg <= lzc64({16'b0, s1_mp_reg});
        s2_lzc_reg <= lzc64({40'b0, s1_mc_reg});
    end

    // stage 3: normalize both to bit 62, order by exponent
    logic [63:0]        mpn, mcn;
    logic signed [11:0] xpn, xcn;
    logic [63:0]        ml_next, msm_next;
    logic signed [11:0] el_next, d_next;
    logic               sl_next, ssm_next;

    always_comb
    begin
        mpn = {16'b0, s2_mp_reg} << 6'(s2_lzp_reg - 7'd1);
        mcn = {40'b0, s2_mc_reg} << 6'(s2_lzc_reg - 7'd1);
        xpn = s2_xp_reg - $signed({5'b0, s2_lzp_reg}) + 12'sd1;
        xcn = s2_xc_reg - $signed({5'b0, s2_lzc_reg}) + 12'sd1;
        if (s2_cz_reg || (xpn >= xcn))
        begin
            ml_next  = mpn;  el_next = xpn; sl_next  = s2_ps_reg;
            msm_next = mcn;  d_next  = xpn - xcn;
            ssm_next = s2_cz_reg ? s2_ps_reg : s2_cs_reg;
        end
        else
        begin
            ml_next  = mcn;  el_next = xcn; sl_next  = s2_cs_reg;
            msm_next = mpn;  d_next  = xcn - xpn;
            ssm_next = s2_ps_reg;
        end
    end

    logic [63:0]        s3_ml_reg, s3_msm_reg;
    logic signed [11:0] s3_el_reg, s3_d_reg;
    logic               s3_sl_reg, s3_ssm_reg, s3_cz_reg;

    always_ff @(posedge clk)
    begin
        s3_ml_reg  <= ml_next;
        s3_msm_reg <= msm_next;
        s3_el_reg  <= el_next;
        s3_d_reg   <= d_next;
        s3_sl_reg  <= sl_next;
        s3_ssm_reg <= ssm_next;
        s3_cz_reg  <= s2_cz_reg;
    end

    // stage 4: align smaller operand with sticky jam
    logic [63:0] s_al;
    logic [63:0] t_sh, lost_mask;

    always_comb
    begin
        t_sh      = s3_msm_reg >> 6'(s3_d_reg);
        lost_mask = (64'd1 << 6'(s3_d_reg)) - 64'd1;
        if (s3_cz_reg)
            s_al = '0;
        else if (s3_d_reg == 12'sd0)
            s_al = s3_msm_reg;
        else if (s3_d_reg >= 12'sd63)
            s_al = 64'd1;
        else if ((s3_msm_reg & lost_mask) != '0)
            s_al = t_sh | 64'd1;
        else
            s_al = t_sh;
    end

    logic [63:0]        s4_ml_reg, s4_s_reg;
    logic signed [11:0] s4_el_reg;
    logic               s4_sl_reg, s4_ssm_reg;

    always_ff @(posedge clk)
    begin
        s4_ml_reg  <= s3_ml_reg;
        s4_s_reg   <= s_al;
        s4_el_reg  <= s3_el_reg;
        s4_sl_reg  <= s3_sl_reg;
        s4_ssm_reg <= s3_ssm_reg;
    end

    // stage 5: add or subtract magnitudes
    logic [63:0] r_next;
    logic        rs_next;

    always_comb
    begin
        if (s4_sl_reg == s4_ssm_reg)
        begin
            r_next  = s4_ml_reg + s4_s_reg;
            rs_next = s4_sl_reg;
        end
        else if (s4_ml_reg >= s4_s_reg)
        begin
            r_next  = s4_ml_reg - s4_s_reg;
            rs_next = s4_sl_reg;
        end
        else
        begin
            r_next  = s4_s_reg - s4_ml_reg;
            rs_next = s4_ssm_reg;
        end
    end

    logic [63:0]        s5_r_reg;
    logic signed [11:0] s5_el_reg;
    logic               s5_rs_reg;

    always_ff @(posedge clk)
    begin
        s5_r_reg  <= r_next;
        s5_el_reg <= s4_el_reg;
        s5_rs_reg <= rs_next;
    end

    // stage 6: rounding position
    logic signed [11:0] p6, sh6, lo6;

    always_comb
    begin
        p6  = 12'sd63 - $signed({5'b0, lzc64(s5_r_reg)});
        sh6 = p6 - 12'sd23;
        lo6 = -12'sd149 - s5_el_reg;
        if (lo6 > sh6)
            sh6 = lo6;
    end

    logic [63:0]        s6_r_reg;
    logic signed [11:0] s6_el_reg, s6_sh_reg;
    logic               s6_rs_reg, s6_zero_reg;

    always_ff @(posedge clk)
    begin
        s6_r_reg    <= s5_r_reg;
        s6_el_reg   <= s5_el_reg;
        s6_sh_reg   <= sh6;
        s6_rs_reg   <= s5_rs_reg;
        s6_zero_reg <= (s5_r_reg == '0);
    end

    // stage 7: shift and round to nearest even
    logic [127:0] wide7;
    logic [6:0]   amt7;
    logic [24:0]  m7;
    logic         up7;

    always_comb
    begin
        amt7 = (s6_sh_reg > 12'sd127) ? 7'd127 : 7'(s6_sh_reg);
        wide7 = {s6_r_reg, 64'b0} >> amt7;
        up7 = 1'b0;
        if (s6_sh_reg <= 12'sd0)
            m7 = 25'(s6_r_reg << 5'(-s6_sh_reg));
        else
        begin
            m7  = wide7[88:64];
            up7 = (wide7[63:0] > 64'h8000_0000_0000_0000)
                || ((wide7[63:0] == 64'h8000_0000_0000_0000) && wide7[64]);
            m7  = m7 + 25'(up7);
        end
    end

    logic [24:0]        s7_m_reg;
    logic signed [11:0] s7_el_reg, s7_sh_reg;
    logic               s7_rs_reg, s7_zero_reg;

    always_ff @(posedge clk)
    begin
        s7_m_reg    <= m7;
        s7_el_reg   <= s6_el_reg;
        s7_sh_reg   <= s6_sh_reg;
        s7_rs_reg   <= s6_rs_reg;
        s7_zero_reg <= s6_zero_reg;
    end

    // stage 8: pack
    logic [23:0]        m8;
    logic signed [11:0] sh8, biased8;
    logic [31:0]        res8;

    always_comb
    begin
        m8  = s7_m_reg[23:0];
        sh8 = s7_sh_reg;
        if (s7_m_reg[24])
        begin
            m8  = s7_m_reg[24:1];
            sh8 = s7_sh_reg + 12'sd1;
        end
        biased8 = sh8 + s7_el_reg + 12'sd150;
        if (spec_reg[fmtile_pkg::FMA_LAT-2])
            res8 = spval_reg[fmtile_pkg::FMA_LAT-2];
        else if (s7_zero_reg)
            res8 = 32'h0;
        else if (m8[23])
        begin
            if (biased8 >= 12'sd255)
                res8 = {s7_rs_reg, INF};
            else
                res8 = {s7_rs_reg, biased8[7:0], m8[22:0]};
        end
        else
            res8 = {s7_rs_reg, 8'h00, m8[22:0]};
    end

    logic [31:0] out_value_reg;

    always_ff @(posedge clk)
    begin
        out_value_reg <= res8;
        tag_reg[0]    <= in_tag;
        spec_reg[0]   <= spec_next;
        spval_reg[0]  <= spval_next;
        for (int i = 1; i < fmtile_pkg::FMA_LAT; i++)
            tag_reg[i] <= tag_reg[i-1];
        for (int i = 1; i < fmtile_pkg::FMA_LAT - 1; i++)
        begin
            spec_reg[i]  <= spec_reg[i-1];
            spval_reg[i] <= spval_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[fmtile_pkg::FMA_LAT-2:0], in_valid};
    end

    assign out_valid = v_reg[fmtile_pkg::FMA_LAT-1];
    assign out_tag   = tag_reg[fmtile_pkg::FMA_LAT-1];
    assign out_value = out_value_reg;

endmodule

FILE: hw/rtl/fmtile_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmtile_dp
// datapath: matrix stores, accumulators, fma pipeline, result register
// ----------------------------------------------------------------------------
module fmtile_dp (
    input  logic                   clk,
    input  logic                   rst_n,
    input  fmtile_pkg::req_item_t  req,
    input  fmtile_pkg::dp_cmd_t    cmd,
    input  logic                   res_ready,
    output logic                   res_valid,
    output fmtile_pkg::res_item_t  res,
    output fmtile_pkg::dp_status_t status
);

    localparam int NWORDS = fmtile_pkg::DIM * fmtile_pkg::DIM;

    logic [31:0] mem_a [NWORDS];
    logic [31:0] mem_b [NWORDS];
    logic [31:0] a_q_reg, b_q_reg;

    logic [fmtile_pkg::IDX_W-1:0] row_base_reg, col_base_reg;
    logic [fmtile_pkg::IDX_W-1:0] rd_row, rd_col;

    logic                          s0_valid_reg, s0_first_reg;
    logic [fmtile_pkg::SLOT_W-1:0] s0_slot_reg;

    logic [31:0] acc_reg [fmtile_pkg::NSLOTS];
    logic [fmtile_pkg::SLOT_W-1:0] acc_rd_addr;
    logic [31:0] acc_rd;
    logic [31:0] fma_c;

    logic                          fma_valid;
    logic [fmtile_pkg::SLOT_W-1:0] fma_tag;
    logic [31:0]                   fma_value;

    logic      res_valid_reg;
    fmtile_pkg::res_item_t res_reg;

    assign rd_row = row_base_reg + fmtile_pkg::IDX_W'(cmd.slot[4:2]);
    assign rd_col = col_base_reg + fmtile_pkg::IDX_W'(cmd.slot[1:0]);

    always_ff @(posedge clk)
    begin
        if (cmd.load_tile)
        begin
            row_base_reg <= {req.tile_row_block, 3'b000};
            col_base_reg <= {req.tile_col_block, 2'b00};
        end
    end

    // element stores, one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (cmd.wr_a)
            mem_a[{req.elem_row, req.elem_col}] <= req.elem_value;
        a_q_reg <= mem_a[{rd_row, cmd.k}];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_b)
            mem_b[{req.elem_row, req.elem_col}] <= req.elem_value;
        b_q_reg <= mem_b[{rd_col, cmd.k}];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else
            s0_valid_reg <= cmd.issue;
    end

    always_ff @(posedge clk)
    begin
        s0_slot_reg  <= cmd.slot;
        s0_first_reg <= cmd.first_k;
    end

    assign acc_rd_addr = cmd.emit_load ? cmd.slot : s0_slot_reg;
    assign acc_rd      = acc_reg[acc_rd_addr];
    assign fma_c       = s0_first_reg ? 32'h0 : acc_rd;

    fmtile_fma u_fma (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s0_valid_reg),
        .in_tag    (s0_slot_reg),
        .a         (a_q_reg),
        .b         (b_q_reg),
        .c         (fma_c),
        .out_valid (fma_valid),
        .out_tag   (fma_tag),
        .out_value (fma_value)
    );

    always_ff @(posedge clk)
    begin
        if (fma_valid)
            acc_reg[fma_tag] <= fma_value;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (cmd.emit_load)
            res_valid_reg <= 1'b1;
        else if (res_ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_load)
        begin
            res_reg.out_row      <= rd_row;
            res_reg.out_col      <= rd_col;
            res_reg.out_value    <= acc_rd;
            res_reg.last_of_tile <= cmd.emit_last;
        end
    end

    assign res_valid       = res_valid_reg;
    assign res             = res_reg;
    assign status.res_busy = res_valid_reg && !res_ready;

endmodule

FILE: hw/rtl/fmtile_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmtile_ctrl
// controller: request decode, fma issue sequencing, result emission
// ----------------------------------------------------------------------------
module fmtile_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    input  fmtile_pkg::req_item_t  req,
    output logic                   req_ready,
    input  fmtile_pkg::dp_status_t status,
    output fmtile_pkg::dp_cmd_t    cmd
);

    fmtile_pkg::state_t state_reg, state_next;

    logic [fmtile_pkg::SLOT_W-1:0]  slot_reg, slot_next;
    logic [fmtile_pkg::IDX_W-1:0]   k_reg, k_next;
    logic [fmtile_pkg::DRAIN_W-1:0] drain_reg, drain_next;

    logic accept, elem_ok, tile_ok, run_done, drain_done, emit_done;

    assign accept  = req_valid && req_ready;
    assign elem_ok = (7'(req.elem_row) < 7'(fmtile_pkg::DIM))
                  && (7'(req.elem_col) < 7'(fmtile_pkg::DIM));
    assign tile_ok = (7'({req.tile_row_block, 3'b000}) + 7'(fmtile_pkg::TILE_ROWS)
                        <= 7'(fmtile_pkg::DIM))
                  && (7'({req.tile_col_block, 2'b00}) + 7'(fmtile_pkg::TILE_COLS)
                        <= 7'(fmtile_pkg::DIM));
    assign run_done   = (slot_reg == fmtile_pkg::SLOT_W'(fmtile_pkg::NSLOTS - 1))
                     && (k_reg == fmtile_pkg::IDX_W'(fmtile_pkg::DIM - 1));
    assign drain_done = (drain_reg == fmtile_pkg::DRAIN_W'(fmtile_pkg::DRAIN_CYCLES - 1));
    assign emit_done  = !status.res_busy
                     && (slot_reg == fmtile_pkg::SLOT_W'(fmtile_pkg::NSLOTS - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fmtile_pkg::ST_IDLE:
                if (accept && (req.operation == fmtile_pkg::OP_TILE) && tile_ok)
                    state_next = fmtile_pkg::ST_RUN;
            fmtile_pkg::ST_RUN:
                if (run_done)
                    state_next = fmtile_pkg::ST_DRAIN;
            fmtile_pkg::ST_DRAIN:
                if (drain_done)
                    state_next = fmtile_pkg::ST_EMIT;
            fmtile_pkg::ST_EMIT:
                if (emit_done)
                    state_next = fmtile_pkg::ST_IDLE;
            default:
                state_next = fmtile_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        req_ready     = 1'b0;
        cmd           = '0;
        cmd.slot      = slot_reg;
        cmd.k         = k_reg;
        cmd.first_k   = (k_reg == '0);
        cmd.emit_last = (slot_reg == fmtile_pkg::SLOT_W'(fmtile_pkg::NSLOTS - 1));
        case (state_reg)
            fmtile_pkg::ST_IDLE:
            begin
                req_ready     = 1'b1;
                cmd.wr_a      = req_valid && (req.operation == fmtile_pkg::OP_WR_A) && elem_ok;
                cmd.wr_b      = req_valid && (req.operation == fmtile_pkg::OP_WR_B) && elem_ok;
                cmd.load_tile = req_valid && (req.operation == fmtile_pkg::OP_TILE);
            end
            fmtile_pkg::ST_RUN:
                cmd.issue = 1'b1;
            fmtile_pkg::ST_DRAIN:
                cmd.issue = 1'b0;
            fmtile_pkg::ST_EMIT:
                cmd.emit_load = !status.res_busy;
            default:
                req_ready = 1'b0;
        endcase
    end

    // counters
    always_comb
    begin
        slot_next  = slot_reg;
        k_next     = k_reg;
        drain_next = drain_reg;
        case (state_reg)
            fmtile_pkg::ST_IDLE:
            begin
                slot_next  = '0;
                k_next     = '0;
                drain_next = '0;
            end
            fmtile_pkg::ST_RUN:
            begin
                slot_next = slot_reg + 1'b1;
                if (slot_reg == fmtile_pkg::SLOT_W'(fmtile_pkg::NSLOTS - 1))
                    k_next = k_reg + 1'b1;
            end
            fmtile_pkg::ST_DRAIN:
                drain_next = drain_reg + 1'b1;
            fmtile_pkg::ST_EMIT:
                if (!status.res_busy)
                    slot_next = slot_reg + 1'b1;
            default:
                slot_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fmtile_pkg::ST_IDLE;
            slot_reg  <= '0;
            k_reg     <= '0;
            drain_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
            k_reg     <= k_next;
            drain_reg <= drain_next;
        end
    end

endmodule

FILE: hw/rtl/float_matmul_tile_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float_matmul_tile_engine
// single-precision tile engine computing C = A * transpose(B), 8x4 tiles
// ----------------------------------------------------------------------------
// usage:
//   one request channel (req_valid/req_ready/req) and one result channel
//   (res_valid/res_ready/res), both valid/ready
//   - write A or B element request: stored when accepted, no result
//   - compute request: 32 results in row-major tile order, last_of_tile
//     flags the final one; operation 3 is dropped without a result, and
//     the field widths keep every tile and element index in range
// sequencing:
//   a tile issues 32 x 64 = 2048 multiply-adds on the single pipelined fma
//   unit (one multiply-add per cycle, accumulators rotate over 32 slots),
//   then drains the fma pipeline and hands out the results; the tile rate
//   is set by the one fma unit and the one read port of each element store
// reset:
//   controller returns to idle, result register empties; element stores
//   are not cleared and hold garbage until written
// stall:
//   while res_ready is low the result register holds and emission pauses;
//   new requests are taken once the final result sits in the register
// ----------------------------------------------------------------------------
module float_matmul_tile_engine (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  fmtile_pkg::req_item_t req,
    output logic                  res_valid,
    input  logic                  res_ready,
    output fmtile_pkg::res_item_t res
);

    // command / status link between controller and datapath
    fmtile_pkg::dp_cmd_t    cmd;
    fmtile_pkg::dp_status_t status;

    fmtile_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req       (req),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    fmtile_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .res_ready (res_ready),
        .res_valid (res_valid),
        .res       (res),
        .status    (status)
    );

endmodule

FILE: hw/rtl/fmtile_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmtile_checker
// port-level checks for the tile engine
// ----------------------------------------------------------------------------
module fmtile_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  req_valid,
    input logic                  req_ready,
    input fmtile_pkg::req_item_t req,
    input logic                  res_valid,
    input logic                  res_ready,
    input fmtile_pkg::res_item_t res
);

    // stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("stalled result changed");

    // compute request makes the block busy
    a_tile_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req.operation == fmtile_pkg::OP_TILE) |=> !req_ready)
        else $error("ready after compute request");

    // element writes leave the block ready again in the next cycle
    a_write_fast: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready
        && ((req.operation == fmtile_pkg::OP_WR_A) || (req.operation == fmtile_pkg::OP_WR_B))
        |=> req_ready)
        else $error("not ready after element write");

    // no new request while a tile is still being handed out
    a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.last_of_tile |-> !req_ready)
        else $error("ready during result emission");

endmodule

bind float_matmul_tile_engine fmtile_checker u_fmtile_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
);
